// File: rtl/core/utf8bd_pkg.sv
package utf8bd_pkg;

    localparam logic [20:0] REPL_CP   = 21'h00fffd;
    localparam logic [20:0] MAX_CP    = 21'h10ffff;
    localparam logic [20:0] SURR_LO   = 21'h00d800;
    localparam logic [20:0] SURR_HI   = 21'h00dfff;
    localparam logic [20:0] MIN_CP_2  = 21'h000080;
    localparam logic [20:0] MIN_CP_3  = 21'h000800;
    localparam logic [20:0] MIN_CP_4  = 21'h010000;

    localparam logic [7:0] CONT_MASK  = 8'hc0;
    localparam logic [7:0] CONT_TAG   = 8'h80;

    localparam logic [2:0] LEN_NONE   = 3'd0;
    localparam logic [2:0] LEN_ONE    = 3'd1;
    localparam logic [2:0] LEN_TWO    = 3'd2;
    localparam logic [2:0] LEN_THREE  = 3'd3;
    localparam logic [2:0] LEN_FOUR   = 3'd4;

    typedef struct packed {
        logic [7:0] byte_0;
        logic [7:0] byte_1;
        logic [7:0] byte_2;
        logic [7:0] byte_3;
        logic [2:0] window_size;
    } item_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [1:0]  start_index;
        logic        replaced;
    } result_t;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b < 8'h80)
        begin
            len = LEN_ONE;
        end
        else if (b >= 8'hc2 && b <= 8'hdf)
        begin
            len = LEN_TWO;
        end
        else if (b >= 8'he0 && b <= 8'hef)
        begin
            len = LEN_THREE;
        end
        else if (b >= 8'hf0 && b <= 8'hf4)
        begin
            len = LEN_FOUR;
        end
        else
        begin
            len = LEN_NONE;
        end
        return len;
    endfunction

endpackage

// File: rtl/core/utf8bd_in_reg.sv
module utf8bd_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  utf8bd_pkg::item_t  item,
    input  logic               advance,
    output logic               held_valid,
    output utf8bd_pkg::item_t  held_item
);

    logic               valid_reg;
    logic               valid_next;
    utf8bd_pkg::item_t  data_reg;
    logic               ready;

    assign ready      = !valid_reg || advance;
    assign item_stall = !ready;
    assign held_valid = valid_reg;
    assign held_item  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ready)
        begin
            valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && item_valid)
        begin
            data_reg <= item;
        end
    end

endmodule

// File: rtl/core/utf8bd_decode.sv
module utf8bd_decode (
    input  utf8bd_pkg::item_t    item,
    output utf8bd_pkg::result_t  result
);

    logic [7:0]  w [4];
    logic [2:0]  n;
    logic [1:0]  last;
    logic [1:0]  first;
    logic [2:0]  span;
    logic [2:0]  len;
    logic [7:0]  lead;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [20:0] cp;
    logic        mismatch;
    logic        bad;

    assign w[0] = item.byte_0;
    assign w[1] = item.byte_1;
    assign w[2] = item.byte_2;
    assign w[3] = item.byte_3;

    always_comb
    begin
        unique case (item.window_size)
            3'd0:    n = 3'd1;
            3'd1,
            3'd2,
            3'd3,
            3'd4:    n = item.window_size;
            default: n = 3'd4;
        endcase
    end

    assign last = 2'(n - 3'd1);

    // walk back over continuation bytes to the lead
    always_comb
    begin
        first = last;
        for (int k = 0; k < 3; k++)
        begin
            if (first != 2'd0 && utf8bd_pkg::is_cont(w[first]))
            begin
                first = first - 2'd1;
            end
        end
    end

    assign span     = n - {1'b0, first};
    assign lead     = w[first];
    assign b1       = w[first + 2'd1];
    assign b2       = w[first + 2'd2];
    assign b3       = w[first + 2'd3];
    assign len      = utf8bd_pkg::lead_length(lead);
    assign mismatch = len != span;

    always_comb
    begin
        unique case (len)
            utf8bd_pkg::LEN_ONE:   cp = {14'd0, lead[6:0]};
            utf8bd_pkg::LEN_TWO:   cp = {10'd0, lead[4:0], b1[5:0]};
            utf8bd_pkg::LEN_THREE: cp = {5'd0, lead[3:0], b1[5:0], b2[5:0]};
            utf8bd_pkg::LEN_FOUR:  cp = {lead[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default:               cp = 21'd0;
        endcase
    end

    // overlong, surrogate or out of range
    always_comb
    begin
        bad = (cp > utf8bd_pkg::MAX_CP)
            || (cp >= utf8bd_pkg::SURR_LO && cp <= utf8bd_pkg::SURR_HI);
        unique case (len)
            utf8bd_pkg::LEN_TWO:   bad = bad || (cp < utf8bd_pkg::MIN_CP_2);
            utf8bd_pkg::LEN_THREE: bad = bad || (cp < utf8bd_pkg::MIN_CP_3);
            utf8bd_pkg::LEN_FOUR:  bad = bad || (cp < utf8bd_pkg::MIN_CP_4);
            default:               bad = bad;
        endcase
    end

    always_comb
    begin
        priority if (mismatch)
        begin
            result.code_point  = utf8bd_pkg::REPL_CP;
            result.start_index = last;
            result.replaced    = 1'b1;
        end
        else if (bad)
        begin
            result.code_point  = utf8bd_pkg::REPL_CP;
            result.start_index = first;
            result.replaced    = 1'b1;
        end
        else
        begin
            result.code_point  = cp;
            result.start_index = first;
            result.replaced    = 1'b0;
        end
    end

endmodule

// File: rtl/core/utf8bd_out_reg.sv
module utf8bd_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 held_valid,
    input  utf8bd_pkg::result_t  decoded,
    output logic                 advance,
    output logic                 result_valid,
    input  logic                 result_stall,
    output utf8bd_pkg::result_t  result
);

    logic                 valid_reg;
    logic                 valid_next;
    utf8bd_pkg::result_t  data_reg;

    assign advance      = held_valid && (!valid_reg || !result_stall);
    assign result_valid = valid_reg;
    assign result       = data_reg;

    always_comb
    begin
        priority if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= decoded;
        end
    end

endmodule

// File: rtl/core/utf8_backward_scalar_decode_unit.sv
// Decodes the last UTF-8 scalar of a one- to four-byte window, walking back from the
// last valid byte to its lead byte, and returns the code point, the window index where
// the scalar starts and a flag set when U+FFFD was substituted. One transaction is
// accepted every cycle unless the result side stalls; it passes through the input
// register, is decoded and is held in the result register until it is taken. The full
// decode is done in the single combinational pass from the input register to the
// result register. A stall on the result side holds the result register and then the
// input register, so no transaction is lost.
module utf8_backward_scalar_decode_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  utf8bd_pkg::item_t    item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output utf8bd_pkg::result_t  result
);

    logic                 held_valid;
    utf8bd_pkg::item_t    held_item;
    utf8bd_pkg::result_t  decoded;
    logic                 advance;

    utf8bd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    utf8bd_decode u_decode (
        .item   (held_item),
        .result (decoded)
    );

    utf8bd_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .held_valid   (held_valid),
        .decoded      (decoded),
        .advance      (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: rtl/core/utf8bd_checker.sv
module utf8bd_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_stall,
    input  logic                 result_valid,
    input  logic                 result_stall,
    input  utf8bd_pkg::result_t  result
);

    a_result_held : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_result_stable : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("stalled result changed");

    a_replaced_value : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.replaced |-> result.code_point == utf8bd_pkg::REPL_CP)
        else $error("replaced result is not U+FFFD");

    a_scalar_legal : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.replaced |->
            result.code_point <= utf8bd_pkg::MAX_CP
            && (result.code_point < utf8bd_pkg::SURR_LO
                || result.code_point > utf8bd_pkg::SURR_HI))
        else $error("decoded scalar out of range or surrogate");

    a_stall_idle_reset : assert property (@(posedge clk)
        !rst_n |=> !result_valid && !item_stall)
        else $error("outputs active in reset");

endmodule

bind utf8_backward_scalar_decode_unit utf8bd_checker u_utf8bd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// File: tb/sv/utf8_backward_scalar_decode_unit_test.sv
module utf8_backward_scalar_decode_unit_test;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 525;

    class decode_scoreboard;
        utf8bd_pkg::result_t expected_q[$];
        int      mismatches;
        int      checked;
        int      substitutions;

        function new();
            mismatches    = 0;
            checked       = 0;
            substitutions = 0;
        endfunction

        function utf8bd_pkg::result_t decode_backward(utf8bd_pkg::item_t it);
            logic [7:0]  w[4];
            int          n;
            int          last;
            int          first;
            int          seq_len;
            int unsigned cp;
            int unsigned min_cp;
            utf8bd_pkg::result_t r;
            w[0] = it.byte_0;
            w[1] = it.byte_1;
            w[2] = it.byte_2;
            w[3] = it.byte_3;
            n = it.window_size;
            if (n == 0)
            begin
                n = 1;
            end
            if (n > 4)
            begin
                n = 4;
            end
            last  = n - 1;
            first = last;
            // walk back over continuation bytes, at most three
            while (first > 0 && w[first][7:6] == 2'b10 && (n - first) < 4)
            begin
                first--;
            end
            if (w[first] < 8'h80)
            begin
                seq_len = 1;
            end
            else if (w[first] >= 8'hc2 && w[first] <= 8'hdf)
            begin
                seq_len = 2;
            end
            else if (w[first] >= 8'he0 && w[first] <= 8'hef)
            begin
                seq_len = 3;
            end
            else if (w[first] >= 8'hf0 && w[first] <= 8'hf4)
            begin
                seq_len = 4;
            end
            else
            begin
                seq_len = 0;
            end
            if (seq_len != n - first)
            begin
                r.code_point  = utf8bd_pkg::REPL_CP;
                r.start_index = 2'(last);
                r.replaced    = 1'b1;
                return r;
            end
            case (seq_len)
                1: cp = w[first] & 8'h7f;
                2: cp = w[first] & 8'h1f;
                3: cp = w[first] & 8'h0f;
                default: cp = w[first] & 8'h07;
            endcase
            for (int i = first + 1; i < n; i++)
            begin
                cp = (cp << 6) | w[i][5:0];
            end
            min_cp = (seq_len == 2) ? utf8bd_pkg::MIN_CP_2
                   : (seq_len == 3) ? utf8bd_pkg::MIN_CP_3 : utf8bd_pkg::MIN_CP_4;
            r.start_index = 2'(first);
            if ((seq_len > 1 && cp < min_cp) || cp > utf8bd_pkg::MAX_CP
                || (cp >= utf8bd_pkg::SURR_LO && cp <= utf8bd_pkg::SURR_HI))
            begin
                r.code_point = utf8bd_pkg::REPL_CP;
                r.replaced   = 1'b1;
            end
            else
            begin
                r.code_point = 21'(cp);
                r.replaced   = 1'b0;
            end
            return r;
        endfunction

        function void note_item(utf8bd_pkg::item_t it);
            expected_q.push_back(decode_backward(it));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_result(utf8bd_pkg::result_t got);
            utf8bd_pkg::result_t exp;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result cp=%h start=%0d repl=%0d",
                                 got.code_point, got.start_index, got.replaced));
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            if (got.replaced)
            begin
                substitutions++;
            end
            if (got.code_point !== exp.code_point)
            begin
                report($sformatf("transaction %0d code_point got %h want %h",
                                 checked, got.code_point, exp.code_point));
            end
            if (got.start_index !== exp.start_index)
            begin
                report($sformatf("transaction %0d start_index got %0d want %0d",
                                 checked, got.start_index, exp.start_index));
            end
            if (got.replaced !== exp.replaced)
            begin
                report($sformatf("transaction %0d replaced got %0d want %0d",
                                 checked, got.replaced, exp.replaced));
            end
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    utf8bd_pkg::item_t   item;
    logic                result_valid;
    logic                result_stall;
    utf8bd_pkg::result_t result;

    decode_scoreboard board = new();
    bit      steady;
    int      cycles = 0;
    int      items_sent;

    utf8_backward_scalar_decode_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles, board.pending());
            $display("status: fail");
            $finish;
        end
    end

    function automatic utf8bd_pkg::item_t make_window(logic [7:0] b0, logic [7:0] b1,
                                                      logic [7:0] b2, logic [7:0] b3,
                                                      logic [2:0] size);
        utf8bd_pkg::item_t it;
        it.byte_0      = b0;
        it.byte_1      = b1;
        it.byte_2      = b2;
        it.byte_3      = b3;
        it.window_size = size;
        return it;
    endfunction

    // called and returns at a falling edge
    task send_item(utf8bd_pkg::item_t it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 19);
        repeat (gap)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        board.note_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    task wait_drained();
        while (board.pending() != 0)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task take_result();
        int gap;
        gap = steady ? 0 : $urandom_range(0, 19);
        repeat (gap)
        begin
            result_stall <= 1'b1;
            @(negedge clk);
        end
        result_stall <= 1'b0;
        do
            @(posedge clk);
        while (!result_valid);
        board.check_result(result);
        @(negedge clk);
    endtask

    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        forever take_result();
    end

    initial
    begin
        utf8bd_pkg::item_t it;
        logic [7:0]  w[4];
        int unsigned cp;
        int          seq_len;
        int          pre;
        int          kind;
        int          bits;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        steady       = 1'b0;
        items_sent   = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ascii extremes, two-byte bounds, overlong and bad leads
        send_item(make_window(8'h00, 8'hff, 8'hff, 8'hff, 3'd1));
        send_item(make_window(8'h7f, 8'h00, 8'h00, 8'h00, 3'd1));
        send_item(make_window(8'hc2, 8'h80, 8'h00, 8'h00, 3'd2));
        send_item(make_window(8'hdf, 8'hbf, 8'h00, 8'h00, 3'd2));
        send_item(make_window(8'hc0, 8'h80, 8'h00, 8'h00, 3'd2));
        send_item(make_window(8'hc1, 8'hbf, 8'h00, 8'h00, 3'd2));
        // three-byte bounds, overlong, surrogates
        send_item(make_window(8'he0, 8'ha0, 8'h80, 8'h00, 3'd3));
        send_item(make_window(8'hef, 8'hbf, 8'hbf, 8'h00, 3'd3));
        send_item(make_window(8'he0, 8'h80, 8'h80, 8'h00, 3'd3));
        send_item(make_window(8'hed, 8'ha0, 8'h80, 8'h00, 3'd3));
        send_item(make_window(8'hed, 8'hbf, 8'hbf, 8'h00, 3'd3));
        // four-byte bounds, above max, overlong, invalid lead
        send_item(make_window(8'hf0, 8'h90, 8'h80, 8'h80, 3'd4));
        send_item(make_window(8'hf4, 8'h8f, 8'hbf, 8'hbf, 3'd4));
        send_item(make_window(8'hf4, 8'h90, 8'h80, 8'h80, 3'd4));
        send_item(make_window(8'hf0, 8'h8f, 8'hbf, 8'hbf, 3'd4));
        send_item(make_window(8'hf5, 8'h80, 8'h80, 8'h80, 3'd4));
        send_item(make_window(8'hff, 8'hff, 8'hff, 8'hff, 3'd4));
        // stray continuations and length mismatch
        send_item(make_window(8'h80, 8'h00, 8'h00, 8'h00, 3'd1));
        send_item(make_window(8'h80, 8'h80, 8'h80, 8'h80, 3'd4));
        send_item(make_window(8'h41, 8'h80, 8'h00, 8'h00, 3'd2));
        send_item(make_window(8'he2, 8'h82, 8'h00, 8'h00, 3'd2));
        // window size out of range and ignored trailing bytes
        send_item(make_window(8'h61, 8'hc3, 8'ha9, 8'hff, 3'd0));
        send_item(make_window(8'hf0, 8'h9f, 8'h98, 8'h80, 3'd7));
        send_item(make_window(8'hc3, 8'ha9, 8'hf8, 8'hbf, 3'd5));
        send_item(make_window(8'he2, 8'h82, 8'hac, 8'h62, 3'd4));
        wait_drained();

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            steady = ((k / 60) % 4) == 2;
            if (k % 150 == 75)
            begin
                wait_drained();
            end
            kind = $urandom_range(0, 9);
            for (int j = 0; j < 4; j++)
            begin
                w[j] = 8'($urandom_range(0, 255));
            end
            if (kind >= 8)
            begin
                it = make_window(w[0], w[1], w[2], w[3], 3'($urandom_range(0, 7)));
            end
            else
            begin
                seq_len = $urandom_range(1, 4);
                pre     = $urandom_range(0, 4 - seq_len);
                bits    = (seq_len == 1) ? 7 : (seq_len == 2) ? 11 : (seq_len == 3) ? 16 : 21;
                if ($urandom_range(0, 7) == 0)
                begin
                    cp = $urandom_range(0, (1 << bits) - 1);
                end
                else
                begin
                    case (seq_len)
                        1: cp = $urandom_range(32'h0, 32'h7f);
                        2: cp = $urandom_range(32'h80, 32'h7ff);
                        3: cp = $urandom_range(32'h800, 32'hffff);
                        default: cp = $urandom_range(32'h10000, 32'h10ffff);
                    endcase
                end
                case (seq_len)
                    1: w[pre] = {1'b0, cp[6:0]};
                    2:
                    begin
                        w[pre]     = {3'b110, cp[10:6]};
                        w[pre + 1] = {2'b10, cp[5:0]};
                    end
                    3:
                    begin
                        w[pre]     = {4'b1110, cp[15:12]};
                        w[pre + 1] = {2'b10, cp[11:6]};
                        w[pre + 2] = {2'b10, cp[5:0]};
                    end
                    default:
                    begin
                        w[pre]     = {5'b11110, cp[20:18]};
                        w[pre + 1] = {2'b10, cp[17:12]};
                        w[pre + 2] = {2'b10, cp[11:6]};
                        w[pre + 3] = {2'b10, cp[5:0]};
                    end
                endcase
                // broken sequence: one flipped bit
                if (kind >= 6)
                begin
                    w[$urandom_range(0, 3)][$urandom_range(0, 7)] ^= 1'b1;
                end
                it = make_window(w[0], w[1], w[2], w[3], 3'(pre + seq_len));
            end
            send_item(it);
        end
        item_valid <= 1'b0;
        steady = 1'b0;

        while (board.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("sent %0d windows (directed edge cases, well-formed, corrupted, noise)",
                 items_sent);
        $display("checked %0d results, %0d with substitution, %0d mismatches, %0d cycles",
                 board.checked, board.substitutions, board.mismatches, cycles);
        if (board.mismatches == 0 && board.pending() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
